>>> hdl/bin_cell_first_fit_allocator_top_defines.svh
`ifndef BIN_CELL_FIRST_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define BIN_CELL_FIRST_FIT_ALLOCATOR_TOP_DEFINES_SVH

// Check that holds in the same cycle.
`define BCFFA_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that holds in the cycle after the trigger.
`define BCFFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bcffa_pkg.sv
`timescale 1ns / 1ps
package bcffa_pkg;

    localparam logic [0:0]  CMD_ALLOC = 1'b0;
    localparam logic [31:0] TAIL_TAG  = 32'hffff_ffff;
    localparam int          HDR_BYTES = 32;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_BAD_OFF  = 3'd2,
        ST_ALREADY  = 3'd3,
        ST_TOO_BIG  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_START,
        OP_RD_W,
        OP_RD_T,
        OP_STEP,
        OP_NEXT_BIN,
        OP_NEW_BIN,
        OP_TAKE,
        OP_WR_REST,
        OP_WR_RTAG,
        OP_WR_SIZE,
        OP_WR_STAG,
        OP_RD_FREE,
        OP_WR_FREE,
        OP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_alloc;
        logic too_large;
        logic bin_at_open;
        logic full;
        logic walk_end;
        logic fits;
        logic tail_free;
        logic bad_step;
        logic has_rest;
        logic rem_ge;
        logic free_bad;
        logic rd_used;
    } t_dp_flags;

endpackage

>>> hdl/bcffa_dp.sv
`timescale 1ns / 1ps
`include "bin_cell_first_fit_allocator_top_defines.svh"
module bcffa_dp #(
    parameter int NUM_BINS  = 16,
    parameter int BIN_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcffa_pkg::t_dp_cmd i_cmd,
    input  logic               i_in_cmd,
    input  logic [11:0]        i_in_payload,
    input  logic [15:0]        i_in_offset,
    output bcffa_pkg::t_dp_flags o_flags,
    output logic [2:0]         o_status,
    output logic [15:0]        o_given_offset,
    output logic [11:0]        o_given_length
);
    localparam int DATA_BYTES  = (BIN_BYTES - bcffa_pkg::HDR_BYTES) & ~7;
    localparam int BIN_WORDS   = DATA_BYTES / 4;
    localparam int STORE_WORDS = NUM_BINS * BIN_WORDS;
    localparam int AW = $clog2(STORE_WORDS);
    localparam int PW = $clog2(DATA_BYTES + 1);
    localparam int BW = $clog2(NUM_BINS + 1);

    logic [31:0]   mem [STORE_WORDS];
    logic [31:0]   r_rdata, r_w;
    logic [AW-1:0] r_base, r_clr;
    logic [PW-1:0] r_pos, r_avail;
    logic [BW-1:0] r_bin, r_bins_open;
    logic [15:0]   r_bbyte;
    logic [16:0]   r_rem;
    logic [12:0]   r_size;
    logic          r_cmd, r_tail;
    logic [2:0]    r_st;
    logic [15:0]   r_goff;
    logic [11:0]   r_glen;

    logic [31:0]   pos32, room32, step32, avail32;
    logic [15:0]   rel16;
    logic          used, tail;
    logic [AW-1:0] a_pos, a_rest, a_rel, ra, wa;
    logic [31:0]   wd;
    logic          we, re;

    always_comb begin
        pos32   = 32'(r_pos);
        room32  = 32'(DATA_BYTES) - pos32;
        used    = r_w[31];
        step32  = used ? (~r_w + 32'd1) : r_w;
        tail    = (r_rdata == bcffa_pkg::TAIL_TAG);
        avail32 = tail ? room32 : r_w;
        rel16   = r_rem[15:0] - 16'(bcffa_pkg::HDR_BYTES);
        a_pos   = AW'(32'(r_base) + (pos32 >> 2));
        a_rest  = AW'(32'(r_base) + ((pos32 + 32'(r_size)) >> 2));
        a_rel   = AW'(32'(r_base) + 32'(rel16[15:2]));

        o_flags.clr_done    = (r_clr == AW'(STORE_WORDS - 1));
        o_flags.is_alloc    = (r_cmd == bcffa_pkg::CMD_ALLOC);
        o_flags.too_large   = (32'(r_size) > 32'(DATA_BYTES));
        o_flags.bin_at_open = (r_bin == r_bins_open);
        o_flags.full        = (r_bins_open == BW'(NUM_BINS));
        o_flags.walk_end    = (pos32 + 32'd8 > 32'(DATA_BYTES));
        o_flags.fits        = !used && (avail32 >= 32'(r_size)) && (avail32 <= room32);
        o_flags.tail_free   = !used && tail;
        o_flags.bad_step    = (step32 == 32'd0) || (step32[2:0] != 3'd0) || (step32 > room32);
        o_flags.has_rest    = (r_avail > PW'(r_size));
        o_flags.rem_ge      = (r_rem >= 17'(BIN_BYTES));
        o_flags.free_bad    = (r_rem[15:0] < 16'(bcffa_pkg::HDR_BYTES)) ||
                              (rel16[1:0] != 2'd0) ||
                              (32'(rel16) + 32'd4 > 32'(DATA_BYTES));
        o_flags.rd_used     = r_rdata[31];

        we = 1'b0;
        wa = a_pos;
        wd = 32'd0;
        re = 1'b0;
        ra = a_pos;
        unique case (i_cmd.op)
            bcffa_pkg::OP_CLEAR: begin
                we = 1'b1;
                wa = r_clr;
            end
            bcffa_pkg::OP_RD_W: re = 1'b1;
            bcffa_pkg::OP_RD_T: begin
                re = 1'b1;
                ra = a_pos + AW'(1);
            end
            bcffa_pkg::OP_RD_FREE: begin
                re = 1'b1;
                ra = a_rel;
            end
            bcffa_pkg::OP_WR_REST: begin
                we = 1'b1;
                wa = a_rest;
                wd = 32'(r_avail) - 32'(r_size);
            end
            bcffa_pkg::OP_WR_RTAG: begin
                we = 1'b1;
                wa = a_rest + AW'(1);
                wd = r_tail ? bcffa_pkg::TAIL_TAG : 32'd0;
            end
            bcffa_pkg::OP_WR_SIZE: begin
                we = 1'b1;
                wd = ~32'(r_size) + 32'd1;
            end
            bcffa_pkg::OP_WR_STAG: begin
                we = 1'b1;
                wa = a_pos + AW'(1);
            end
            bcffa_pkg::OP_WR_FREE: begin
                we = 1'b1;
                wa = a_rel;
                wd = ~r_rdata + 32'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_bins_open <= '0;
            r_bin       <= '0;
            r_pos       <= '0;
        end else begin
            unique case (i_cmd.op)
                bcffa_pkg::OP_CLEAR: r_clr <= r_clr + AW'(1);
                bcffa_pkg::OP_START: begin
                    r_cmd   <= i_in_cmd;
                    r_size  <= (13'(i_in_payload) + 13'd11) & ~13'd7;
                    r_rem   <= 17'(i_in_offset);
                    r_bin   <= '0;
                    r_base  <= '0;
                    r_bbyte <= '0;
                    r_pos   <= '0;
                end
                bcffa_pkg::OP_RD_T: r_w <= r_rdata;
                bcffa_pkg::OP_STEP: r_pos <= PW'(pos32 + step32);
                bcffa_pkg::OP_NEXT_BIN: begin
                    r_bin   <= r_bin + BW'(1);
                    r_base  <= r_base + AW'(BIN_WORDS);
                    r_bbyte <= r_bbyte + 16'(BIN_BYTES);
                    r_rem   <= r_rem - 17'(BIN_BYTES);
                    r_pos   <= '0;
                end
                bcffa_pkg::OP_NEW_BIN: begin
                    r_bins_open <= r_bins_open + BW'(1);
                    r_avail     <= PW'(DATA_BYTES);
                    r_tail      <= 1'b1;
                end
                bcffa_pkg::OP_TAKE: begin
                    r_avail <= PW'(avail32);
                    r_tail  <= tail;
                end
                bcffa_pkg::OP_RESULT: begin
                    r_st <= i_cmd.status;
                    if (i_cmd.status == bcffa_pkg::ST_OK && r_cmd == bcffa_pkg::CMD_ALLOC) begin
                        r_goff <= r_bbyte + 16'(pos32) + 16'(bcffa_pkg::HDR_BYTES);
                        r_glen <= 12'(r_size - 13'd4);
                    end else begin
                        r_goff <= '0;
                        r_glen <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status       = r_st;
    assign o_given_offset = r_goff;
    assign o_given_length = r_glen;

    `BCFFA_ASSERT_NOW(a_bins_bound, r_bins_open <= BW'(NUM_BINS), "bins_open past NUM_BINS")
    `BCFFA_ASSERT_NOW(a_new_bin_room,
        i_cmd.op != bcffa_pkg::OP_NEW_BIN || r_bins_open < BW'(NUM_BINS), "bin opened when full")
    `BCFFA_ASSERT_NOW(a_pos_align, r_pos[2:0] == 3'd0, "walk position not 8-byte aligned")
endmodule

>>> hdl/bcffa_ctrl.sv
`timescale 1ns / 1ps
`include "bin_cell_first_fit_allocator_top_defines.svh"
module bcffa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  bcffa_pkg::t_dp_flags i_flags,
    output bcffa_pkg::t_dp_cmd   o_cmd
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_CHECK, S_RD_TAG, S_EVAL,
        S_WR_REST, S_WR_RTAG, S_WR_SIZE, S_WR_STAG, S_FDIV, S_FCHK, S_RESULT
    } t_state;

    t_state              r_state, n_state;
    bcffa_pkg::t_status  r_status, n_status;
    logic                r_out_valid;
    logic                slot_free;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_cmd.op     = bcffa_pkg::OP_IDLE;
        o_cmd.status = r_status;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = bcffa_pkg::OP_CLEAR;
                if (i_flags.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = bcffa_pkg::OP_START;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_flags.is_alloc) begin
                    n_state = S_FDIV;
                end else if (i_flags.too_large) begin
                    n_status = bcffa_pkg::ST_TOO_BIG;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_flags.bin_at_open) begin
                    if (i_flags.full) begin
                        n_status = bcffa_pkg::ST_NO_SPACE;
                        n_state  = S_RESULT;
                    end else begin
                        o_cmd.op = bcffa_pkg::OP_NEW_BIN;
                        n_state  = S_WR_REST;
                    end
                end else if (i_flags.walk_end) begin
                    o_cmd.op = bcffa_pkg::OP_NEXT_BIN;
                end else begin
                    o_cmd.op = bcffa_pkg::OP_RD_W;
                    n_state  = S_RD_TAG;
                end
            end
            S_RD_TAG: begin
                o_cmd.op = bcffa_pkg::OP_RD_T;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_CHECK;
                if (i_flags.fits) begin
                    o_cmd.op = bcffa_pkg::OP_TAKE;
                    n_state  = S_WR_REST;
                end else if (i_flags.tail_free || i_flags.bad_step) begin
                    o_cmd.op = bcffa_pkg::OP_NEXT_BIN;
                end else begin
                    o_cmd.op = bcffa_pkg::OP_STEP;
                end
            end
            S_WR_REST: begin
                if (i_flags.has_rest) begin
                    o_cmd.op = bcffa_pkg::OP_WR_REST;
                    n_state  = S_WR_RTAG;
                end else begin
                    n_state = S_WR_SIZE;
                end
            end
            S_WR_RTAG: begin
                o_cmd.op = bcffa_pkg::OP_WR_RTAG;
                n_state  = S_WR_SIZE;
            end
            S_WR_SIZE: begin
                o_cmd.op = bcffa_pkg::OP_WR_SIZE;
                n_state  = S_WR_STAG;
            end
            S_WR_STAG: begin
                o_cmd.op = bcffa_pkg::OP_WR_STAG;
                n_status = bcffa_pkg::ST_OK;
                n_state  = S_RESULT;
            end
            S_FDIV: begin
                if (i_flags.bin_at_open) begin
                    n_status = bcffa_pkg::ST_BAD_OFF;
                    n_state  = S_RESULT;
                end else if (i_flags.rem_ge) begin
                    o_cmd.op = bcffa_pkg::OP_NEXT_BIN;
                end else if (i_flags.free_bad) begin
                    n_status = bcffa_pkg::ST_BAD_OFF;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.op = bcffa_pkg::OP_RD_FREE;
                    n_state  = S_FCHK;
                end
            end
            S_FCHK: begin
                n_state = S_RESULT;
                if (!i_flags.rd_used) begin
                    n_status = bcffa_pkg::ST_ALREADY;
                end else begin
                    o_cmd.op = bcffa_pkg::OP_WR_FREE;
                    n_status = bcffa_pkg::ST_OK;
                end
            end
            S_RESULT: begin
                if (slot_free) begin
                    o_cmd.op = bcffa_pkg::OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_status    <= bcffa_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            if (r_state == S_RESULT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `BCFFA_ASSERT_NEXT(a_one_item,
        i_in_valid && o_in_ready, !o_in_ready, "second word taken mid-operation")
    `BCFFA_ASSERT_NEXT(a_result_shown,
        o_cmd.op == bcffa_pkg::OP_RESULT, r_out_valid, "result lost")
endmodule

>>> hdl/bin_cell_first_fit_allocator_top.sv
`timescale 1ns / 1ps
// First-fit cell allocator over NUM_BINS bins of BIN_BYTES each, one result word per
// input word. After reset a clearing pass writes NUM_BINS*((BIN_BYTES-32)&~7)/4 store
// words, one per cycle (16256 words by default), before the first word is taken.
// The store is a single-port-read memory, so an allocate reads each visited cell's
// word and then its tag, bin by bin, then splits, writes and reports; a free steps bin
// by bin to its index, reads and rewrites the cell. One operation is in flight at a time.
module bin_cell_first_fit_allocator_top #(
    parameter int NUM_BINS  = 16,
    parameter int BIN_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // payload_bytes[11:0], cell_offset[27:12]
    input  logic [0:0]  i_s_tuser,   // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // given_offset[15:0], given_length[27:16]
    output logic [2:0]  o_m_tuser    // status
);
    bcffa_pkg::t_dp_cmd   cmd;
    bcffa_pkg::t_dp_flags flags;
    logic [2:0]           status;
    logic [15:0]          goff;
    logic [11:0]          glen;

    bcffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    bcffa_dp #(
        .NUM_BINS  (NUM_BINS),
        .BIN_BYTES (BIN_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_in_cmd       (i_s_tuser[0]),
        .i_in_payload   (i_s_tdata[11:0]),
        .i_in_offset    (i_s_tdata[27:12]),
        .o_flags        (flags),
        .o_status       (status),
        .o_given_offset (goff),
        .o_given_length (glen)
    );

    assign o_m_tdata = {4'd0, glen, goff};
    assign o_m_tuser = status;
endmodule

>>> bench/bin_cell_first_fit_allocator_top_tb.sv
`timescale 1ns / 1ps
module bin_cell_first_fit_allocator_top_tb;
    import bcffa_pkg::*;

    localparam int NUM_BINS   = 16;
    localparam int BIN_BYTES  = 4096;
    localparam int DATA_BYTES = (BIN_BYTES - HDR_BYTES) & ~7;
    localparam int BIN_WORDS  = DATA_BYTES / 4;
    localparam int N_RANDOM   = 1000;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 3000;
    localparam longint LIMIT  = 20_000_000;

    typedef struct packed {
        logic [0:0]  cmd;
        logic [11:0] payload;
        logic [15:0] offset;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [15:0] off;
        logic [11:0] len;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [0:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic [2:0]  o_m_tuser;

    bin_cell_first_fit_allocator_top #(
        .NUM_BINS (NUM_BINS),
        .BIN_BYTES(BIN_BYTES)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // allocator shadow
    logic [31:0] cell_mem [NUM_BINS * BIN_WORDS];
    int          open_bins;
    t_req        pending_reqs[$];
    t_resp       expected_resps[$];
    logic [15:0] live_cells[$];
    int          n_ok, n_nospace, n_badoff, n_already, n_toobig;
    int          errors, mismatches;
    longint      cycles;

    function automatic t_resp claim_cell(int b, int pos, logic [31:0] size,
                                         logic [31:0] avail, bit tail);
        t_resp r;
        int    base;
        base = b * BIN_WORDS;
        if (avail > size) begin
            cell_mem[base + (pos + size) / 4]     = avail - size;
            cell_mem[base + (pos + size) / 4 + 1] = tail ? TAIL_TAG : 32'd0;
        end
        cell_mem[base + pos / 4]     = ~size + 32'd1;
        cell_mem[base + pos / 4 + 1] = 32'd0;
        r.status = ST_OK;
        r.off    = 16'(b * BIN_BYTES + pos + HDR_BYTES);
        r.len    = 12'(size - 4);
        return r;
    endfunction

    function automatic t_resp alloc_cell(logic [11:0] payload);
        t_resp       r;
        logic [31:0] size, w, tag, step, room, avail;
        int          pos;
        bit          tail;
        r    = '{status: ST_OK, off: '0, len: '0};
        size = (32'(payload) + 32'd11) & ~32'd7;
        if (size > DATA_BYTES) begin
            r.status = ST_TOO_BIG;
            return r;
        end
        for (int b = 0; b < open_bins; b++) begin
            pos = 0;
            while (pos + 8 <= DATA_BYTES) begin
                w   = cell_mem[b * BIN_WORDS + pos / 4];
                tag = cell_mem[b * BIN_WORDS + pos / 4 + 1];
                if (w[31]) begin
                    step = ~w + 32'd1;
                end else begin
                    tail  = (tag == TAIL_TAG);
                    room  = DATA_BYTES - pos;
                    avail = tail ? room : w;
                    if (avail >= size && avail <= room)
                        return claim_cell(b, pos, size, avail, tail);
                    if (tail) break;
                    step = w;
                end
                if (step == 0 || step[2:0] != 0 || step > DATA_BYTES - pos) break;
                pos += int'(step);
            end
        end
        if (open_bins < NUM_BINS) begin
            open_bins++;
            return claim_cell(open_bins - 1, 0, size, DATA_BYTES, 1'b1);
        end
        r.status = ST_NO_SPACE;
        return r;
    endfunction

    function automatic t_resp release_cell(logic [15:0] off);
        t_resp r;
        int    b, inner, rel, idx;
        r     = '{status: ST_BAD_OFF, off: '0, len: '0};
        b     = int'(off) / BIN_BYTES;
        inner = int'(off) - b * BIN_BYTES;
        rel   = inner - HDR_BYTES;
        if (b >= open_bins || inner < HDR_BYTES || rel % 4 != 0 || rel + 4 > DATA_BYTES)
            return r;
        idx = b * BIN_WORDS + rel / 4;
        if (!cell_mem[idx][31]) begin
            r.status = ST_ALREADY;
            return r;
        end
        cell_mem[idx] = ~cell_mem[idx] + 32'd1;
        r.status = ST_OK;
        return r;
    endfunction

    function automatic t_resp queue_op(logic [0:0] cmd, logic [11:0] payload,
                                       logic [15:0] off);
        t_resp r;
        r = (cmd == CMD_ALLOC) ? alloc_cell(payload) : release_cell(off);
        pending_reqs.push_back('{cmd: cmd, payload: payload, offset: off});
        expected_resps.push_back(r);
        case (r.status)
            ST_OK:       n_ok++;
            ST_NO_SPACE: n_nospace++;
            ST_BAD_OFF:  n_badoff++;
            ST_ALREADY:  n_already++;
            default:     n_toobig++;
        endcase
        if (cmd == CMD_ALLOC && r.status == ST_OK) live_cells.push_back(r.off);
        return r;
    endfunction

    function automatic logic [11:0] pick_payload();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return 12'($urandom_range(0, 255));
        if (k < 90) return 12'($urandom_range(256, 1023));
        return 12'($urandom());
    endfunction

    // stimulus and expectations, built in order of issue
    initial begin
        t_resp       r;
        logic [15:0] first_off, off;
        int          k, j;
        foreach (cell_mem[i]) cell_mem[i] = '0;
        open_bins = 0;
        r = queue_op(CMD_ALLOC, 12'd0, 16'hffff);
        first_off = r.off;
        r = queue_op(CMD_ALLOC, 12'hfff, 16'h0);
        r = queue_op(CMD_ALLOC, 12'd4061, 16'h0);
        r = queue_op(~CMD_ALLOC, 12'hfff, first_off);
        r = queue_op(~CMD_ALLOC, 12'h0, first_off);
        r = queue_op(~CMD_ALLOC, 12'h0, 16'h0010);
        r = queue_op(~CMD_ALLOC, 12'h0, 16'h0022);
        r = queue_op(~CMD_ALLOC, 12'h0, 16'h0028);
        r = queue_op(~CMD_ALLOC, 12'h0, 16'h1020);
        r = queue_op(~CMD_ALLOC, 12'h0, 16'hfffc);
        for (int i = 0; i < 15; i++) r = queue_op(CMD_ALLOC, 12'd4060, 16'($urandom()));
        r = queue_op(CMD_ALLOC, 12'd0, 16'h0);
        r = queue_op(~CMD_ALLOC, 12'h0, 16'h1ffc);
        for (int i = 0; i < N_RANDOM; i++) begin
            k = $urandom_range(0, 99);
            if (k < 55 || live_cells.size() == 0) begin
                r = queue_op(CMD_ALLOC, pick_payload(), 16'($urandom()));
            end else begin
                j   = $urandom_range(0, live_cells.size() - 1);
                off = live_cells[j];
                if (k < 85) begin
                    if ($urandom_range(0, 9) < 7) live_cells.delete(j);
                end else if (k < 93) begin
                    off = off + 16'($urandom_range(0, 4) * 4) - 16'd8;
                end else begin
                    off = 16'($urandom());
                end
                r = queue_op(~CMD_ALLOC, 12'($urandom()), off);
            end
        end
    end

    // sender
    int issued;
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap   <= 0;
            issued     <= 0;
        end else if (!(i_s_tvalid && !o_s_tready)) begin
            if (send_gap > 0) begin
                i_s_tvalid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (issued < pending_reqs.size()) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {4'd0, pending_reqs[issued].offset, pending_reqs[issued].payload};
                i_s_tuser  <= pending_reqs[issued].cmd;
                issued     <= issued + 1;
                send_gap   <= ((issued / 100) % 3 == 1) ? 0 : $urandom_range(0, 14);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    int    received;
    int    recv_gap;
    int    hold_left;
    bit    held;
    t_resp got, want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            recv_gap   <= 0;
            received   <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                received <= received + 1;
                got = '{status: t_status'(o_m_tuser), off: o_m_tdata[15:0],
                        len: o_m_tdata[27:16]};
                if (expected_resps.size() == 0) begin
                    errors++;
                    $display("unexpected word: status %0d off %h len %0d",
                             got.status, got.off, got.len);
                end else begin
                    want = expected_resps.pop_front();
                    if (got != want) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: exp status %0d off %h len %0d, got %0d %h %0d",
                                     received, want.status, want.off, want.len,
                                     got.status, got.off, got.len);
                    end
                end
                recv_gap <= ((received / 100) % 3 == 2) ? 0 : $urandom_range(0, 14);
            end
            if ((!held && received == HOLD_AT) || hold_left > 0) begin
                i_m_tready <= 1'b0;
            end else if (recv_gap > 0 && !(o_m_tvalid && i_m_tready)) begin
                recv_gap   <= recv_gap - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= (o_m_tvalid && i_m_tready) ? 1'b0 : 1'b1;
            end
        end
    end

    // long receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            held      <= 1'b0;
        end else if (!held && received == HOLD_AT) begin
            held      <= 1'b1;
            hold_left <= HOLD_LEN;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        cycles = 0;
        errors = 0;
        mismatches = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() > 0 && issued == pending_reqs.size() && !i_s_tvalid);
        wait (expected_resps.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("%0d requests: %0d ok, %0d no space, %0d bad offset, %0d already free,",
                 pending_reqs.size(), n_ok, n_nospace, n_badoff, n_already);
        $display("%0d too large; %0d errors (%0d mismatches)", n_toobig, errors, mismatches);
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+hdl
hdl/bcffa_pkg.sv
hdl/bcffa_dp.sv
hdl/bcffa_ctrl.sv
hdl/bin_cell_first_fit_allocator_top.sv
bench/bin_cell_first_fit_allocator_top_tb.sv
